>>> sv/i2cts_pkg.sv
// shared types, codes and sizes of the i2c transaction scheduler
package i2cts_pkg;

    localparam int NUM_DEVICES = 4;
    localparam int MAX_STEPS   = 8;
    localparam int LENGTH_BITS = 16;

    localparam int DEV_W    = $clog2(NUM_DEVICES);
    localparam int STEP_W   = $clog2(MAX_STEPS);
    localparam int COUNT_W  = $clog2(MAX_STEPS + 1);
    localparam int ACTIVE_W = $clog2(NUM_DEVICES + 1);
    localparam int ADDR_W   = DEV_W + STEP_W;
    localparam int DEPTH    = NUM_DEVICES * MAX_STEPS;

    localparam int ADDR_BITS = 7;
    localparam int RATE_BITS = 10;
    localparam int TMO_BITS  = 16;

    localparam logic [2:0] CMD_POLL   = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_CANCEL = 3'd2;
    localparam logic [2:0] CMD_DONE   = 3'd3;
    localparam logic [2:0] CMD_ERROR  = 3'd4;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_FAIL   = 3'd3;
    localparam logic [2:0] KIND_ACCEPT = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    localparam logic [1:0] CFG_ADDR    = 2'd0;
    localparam logic [1:0] CFG_BAUD    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_NONE = ACTIVE_W'(NUM_DEVICES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ARB  = 3'd1,
        ST_CONF = 3'd2,
        ST_EXEC = 3'd3,
        ST_WAIT = 3'd4,
        ST_NEXT = 3'd5,
        ST_DONE = 3'd6,
        ST_ERR  = 3'd7
    } state_t;

    typedef struct packed {
        logic [2:0]             command;
        logic [1:0]             device;
        logic [2:0]             step_index;
        logic                   step_is_read;
        logic [LENGTH_BITS-1:0] step_length;
        logic                   step_stop;
        logic [7:0]             step_buffer_tag;
        logic                   step_last;
        logic [31:0]            now_ms;
    } cmd_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [1:0]             out_device;
        logic                   read_not_write;
        logic [6:0]             target_addr;
        logic [9:0]             rate_khz;
        logic [7:0]             buffer_tag;
        logic [LENGTH_BITS-1:0] length;
        logic                   send_stop;
        logic [3:0]             pending_mask;
        logic [2:0]             manager_state;
    } res_t;

    typedef struct packed {
        logic                   is_read;
        logic [LENGTH_BITS-1:0] length;
        logic                   stop;
        logic [7:0]             tag;
    } step_t;

    localparam int STEP_BITS = $bits(step_t);

    typedef struct packed {
        logic [NUM_DEVICES*ADDR_BITS-1:0] slave_addr;
        logic [NUM_DEVICES*RATE_BITS-1:0] baud_khz;
        logic [NUM_DEVICES*TMO_BITS-1:0]  timeout;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        step_t             data;
    } wr_t;

endpackage

>>> sv/i2cts_cmd_if.sv
// command channel of the i2c transaction scheduler
interface i2cts_cmd_if
    import i2cts_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [2:0]             command;
    logic [1:0]             device;
    logic [2:0]             step_index;
    logic                   step_is_read;
    logic [LENGTH_BITS-1:0] step_length;
    logic                   step_stop;
    logic [7:0]             step_buffer_tag;
    logic                   step_last;
    logic [31:0]            now_ms;

    modport source (
        output valid, command, device, step_index, step_is_read, step_length,
               step_stop, step_buffer_tag, step_last, now_ms,
        input  ready
    );

    modport sink (
        input  valid, command, device, step_index, step_is_read, step_length,
               step_stop, step_buffer_tag, step_last, now_ms,
        output ready
    );
endinterface

>>> sv/i2cts_res_if.sv
// result channel of the i2c transaction scheduler
interface i2cts_res_if
    import i2cts_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [2:0]             kind;
    logic [1:0]             out_device;
    logic                   read_not_write;
    logic [6:0]             target_addr;
    logic [9:0]             rate_khz;
    logic [7:0]             buffer_tag;
    logic [LENGTH_BITS-1:0] length;
    logic                   send_stop;
    logic [3:0]             pending_mask;
    logic [2:0]             manager_state;

    modport source (
        output valid, kind, out_device, read_not_write, target_addr, rate_khz,
               buffer_tag, length, send_stop, pending_mask, manager_state,
        input  ready
    );

    modport sink (
        input  valid, kind, out_device, read_not_write, target_addr, rate_khz,
               buffer_tag, length, send_stop, pending_mask, manager_state,
        output ready
    );
endinterface

>>> sv/i2cts_ram.sv
// generic single-write, registered-read ram
module i2cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/i2cts_sched.sv
// scheduler state and per-transaction next-state logic
module i2cts_sched
    import i2cts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cmd_t              item,
    input  cfg_t              cfg,
    input  step_t             step_data,
    output res_t              result,
    output wr_t               wr,
    output logic [ADDR_W-1:0] rd_addr
);
    state_t                state_reg, state_next;
    logic [ACTIVE_W-1:0]   active_reg, active_next;
    logic [NUM_DEVICES-1:0] pending_reg, pending_next;
    logic [COUNT_W-1:0]    count_reg [NUM_DEVICES];
    logic [COUNT_W-1:0]    count_next [NUM_DEVICES];
    logic [STEP_W-1:0]     cur_reg [NUM_DEVICES];
    logic [STEP_W-1:0]     cur_next [NUM_DEVICES];
    logic [31:0]           start_reg, start_next;
    logic                  done_reg, done_next;
    logic                  error_reg, error_next;

    logic [DEV_W-1:0]      dev;
    logic                  dev_ok;
    logic [31:0]           elapsed;
    logic [TMO_BITS-1:0]   timeout;
    logic [COUNT_W-1:0]    step_inc;
    logic                  found;
    logic [DEV_W-1:0]      pick;

    assign dev     = active_reg[DEV_W-1:0];
    assign dev_ok  = active_reg < ACTIVE_NONE;
    assign elapsed = item.now_ms - start_reg;
    assign timeout = cfg.timeout[dev*TMO_BITS +: TMO_BITS];
    assign step_inc = COUNT_W'(cur_reg[dev]) + COUNT_W'(1);

    // lowest pending device wins
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = NUM_DEVICES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                found = 1'b1;
                pick  = DEV_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        done_next    = done_reg;
        error_next   = error_reg;
        result       = '0;
        wr           = '0;

        if (fire)
        begin
            unique case (item.command)
                CMD_POLL:
                begin
                    unique case (state_reg)
                        ST_IDLE:
                        begin
                            if (pending_reg != '0)
                            begin
                                state_next = ST_ARB;
                            end
                        end
                        ST_ARB:
                        begin
                            if (found)
                            begin
                                active_next = ACTIVE_W'(pick);
                                state_next  = ST_CONF;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            if (!dev_ok)
                            begin
                                active_next = ACTIVE_NONE;
                                state_next  = ST_IDLE;
                            end
                            else
                            begin
                                unique case (state_reg)
                                    ST_CONF:
                                    begin
                                        cur_next[dev] = '0;
                                        start_next    = item.now_ms;
                                        done_next     = 1'b0;
                                        error_next    = 1'b0;
                                        state_next    = ST_EXEC;
                                    end
                                    ST_EXEC:
                                    begin
                                        done_next             = 1'b0;
                                        error_next            = 1'b0;
                                        result.kind           = KIND_START;
                                        result.out_device     = 2'(dev);
                                        result.read_not_write = step_data.is_read;
                                        result.target_addr    =
                                            cfg.slave_addr[dev*ADDR_BITS +: ADDR_BITS];
                                        result.rate_khz       =
                                            cfg.baud_khz[dev*RATE_BITS +: RATE_BITS];
                                        result.buffer_tag     = step_data.tag;
                                        result.length         = step_data.length;
                                        result.send_stop      = step_data.stop;
                                        state_next            = ST_WAIT;
                                    end
                                    ST_WAIT:
                                    begin
                                        // completion wins over error
                                        if (done_reg)
                                        begin
                                            state_next = ST_NEXT;
                                        end
                                        else if (error_reg)
                                        begin
                                            state_next = ST_ERR;
                                        end
                                        else if (elapsed >= 32'(timeout))
                                        begin
                                            state_next = ST_ERR;
                                        end
                                    end
                                    ST_NEXT:
                                    begin
                                        cur_next[dev] = step_inc[STEP_W-1:0];
                                        state_next = (step_inc >= count_reg[dev]) ?
                                                     ST_DONE : ST_EXEC;
                                    end
                                    default:
                                    begin
                                        pending_next[dev] = 1'b0;
                                        active_next       = ACTIVE_NONE;
                                        state_next        = ST_IDLE;
                                        result.kind       = (state_reg == ST_DONE) ?
                                                            KIND_DONE : KIND_FAIL;
                                        result.out_device = 2'(dev);
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                CMD_LOAD:
                begin
                    result.out_device = item.device;
                    if (pending_reg[item.device[DEV_W-1:0]])
                    begin
                        result.kind = KIND_REJECT;
                    end
                    else
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = {item.device[DEV_W-1:0],
                                           item.step_index[STEP_W-1:0]};
                        wr.data.is_read = item.step_is_read;
                        wr.data.length  = item.step_length;
                        wr.data.stop    = item.step_stop;
                        wr.data.tag     = item.step_buffer_tag;
                        if (item.step_last)
                        begin
                            count_next[item.device[DEV_W-1:0]] =
                                COUNT_W'(item.step_index[STEP_W-1:0]) + COUNT_W'(1);
                            pending_next[item.device[DEV_W-1:0]] = 1'b1;
                        end
                        result.kind = KIND_ACCEPT;
                    end
                end
                CMD_CANCEL:
                begin
                    pending_next[item.device[DEV_W-1:0]] = 1'b0;
                end
                CMD_DONE:
                begin
                    done_next = 1'b1;
                end
                CMD_ERROR:
                begin
                    error_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        result.pending_mask  = 4'(pending_next);
        result.manager_state = state_next;
    end

    // step store read follows the state that the next poll will see
    assign rd_addr = {active_next[DEV_W-1:0], cur_next[active_next[DEV_W-1:0]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= ACTIVE_NONE;
            pending_reg <= '0;
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                count_reg[i] <= '0;
                cur_reg[i]   <= '0;
            end
            start_reg   <= '0;
            done_reg    <= 1'b0;
            error_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            start_reg   <= start_next;
            done_reg    <= done_next;
            error_reg   <= error_next;
        end
    end
endmodule

>>> sv/i2c_transaction_arbiter_sequencer_core.sv
// top level: channel registers, configuration, step store and scheduler
// a transaction passes from the input register through the single scheduler
// pass into the result register, and stalls while a result is held back
// throughput: one transaction per cycle while no result is held back
// reset: asynchronous active low; idle, nothing pending, tables zero,
// step store contents undefined until loaded
module i2c_transaction_arbiter_sequencer_core
    import i2cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cts_cmd_if.sink   cmd,
    i2cts_res_if.source rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic              in_valid_reg;
    cmd_t              in_item_reg;
    logic              out_valid_reg;
    res_t              out_item_reg;
    cfg_t              cfg_reg;
    logic              fire;
    res_t              result;
    wr_t               wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [STEP_BITS-1:0] ram_rdata;
    logic              fwd_valid_reg;
    step_t             fwd_data_reg;
    step_t             step_data;

    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_item_reg.command         <= cmd.command;
            in_item_reg.device          <= cmd.device;
            in_item_reg.step_index      <= cmd.step_index;
            in_item_reg.step_is_read    <= cmd.step_is_read;
            in_item_reg.step_length     <= cmd.step_length;
            in_item_reg.step_stop       <= cmd.step_stop;
            in_item_reg.step_buffer_tag <= cmd.step_buffer_tag;
            in_item_reg.step_last       <= cmd.step_last;
            in_item_reg.now_ms          <= cmd.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADDR:    cfg_reg.slave_addr <= cfg_data[NUM_DEVICES*ADDR_BITS-1:0];
                CFG_BAUD:    cfg_reg.baud_khz   <= cfg_data[NUM_DEVICES*RATE_BITS-1:0];
                CFG_TIMEOUT: cfg_reg.timeout    <= cfg_data[NUM_DEVICES*TMO_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    i2cts_ram #(
        .WIDTH (STEP_BITS),
        .DEPTH (DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // a load into the slot being read this cycle is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr.data;
    end

    assign step_data = fwd_valid_reg ? fwd_data_reg : step_t'(ram_rdata);

    i2cts_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .step_data (step_data),
        .result    (result),
        .wr        (wr),
        .rd_addr   (rd_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_item_reg.kind;
    assign rsp.out_device     = out_item_reg.out_device;
    assign rsp.read_not_write = out_item_reg.read_not_write;
    assign rsp.target_addr    = out_item_reg.target_addr;
    assign rsp.rate_khz       = out_item_reg.rate_khz;
    assign rsp.buffer_tag     = out_item_reg.buffer_tag;
    assign rsp.length         = out_item_reg.length;
    assign rsp.send_stop      = out_item_reg.send_stop;
    assign rsp.pending_mask   = out_item_reg.pending_mask;
    assign rsp.manager_state  = out_item_reg.manager_state;

    // a started transfer always leaves the manager waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.kind == KIND_START) |-> (rsp.manager_state == ST_WAIT))
        else $error("start transfer without wait state");

    // a finished or failed request returns to idle with its pending bit clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && ((rsp.kind == KIND_DONE) || (rsp.kind == KIND_FAIL)) |->
        (rsp.manager_state == ST_IDLE) && !rsp.pending_mask[rsp.out_device])
        else $error("request finish left state or pending bit behind");

    // the command side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> rsp.valid && !rsp.ready)
        else $error("command stalled without result back-pressure");
endmodule

>>> tb/tb_i2c_transaction_arbiter_sequencer_core.sv
// testbench of the i2c transaction scheduler: directed table, random traffic, scoreboard
module tb_i2c_transaction_arbiter_sequencer_core;
    import i2cts_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ADDR;
    logic [63:0] cfg_data = '0;

    i2cts_cmd_if cmd_ch ();
    i2cts_res_if res_ch ();

    i2c_transaction_arbiter_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scheduler model state
    state_t                   mgr_state = ST_IDLE;
    logic [ACTIVE_W-1:0]      active_dev = ACTIVE_NONE;
    logic [NUM_DEVICES-1:0]   pend = '0;
    int unsigned              step_cnt [NUM_DEVICES];
    int unsigned              cur_step [NUM_DEVICES];
    step_t                    slots [DEPTH];
    logic [MAX_STEPS-1:0]     slot_written [NUM_DEVICES];
    logic [31:0]              t_start = '0;
    logic                     flag_done = 1'b0;
    logic                     flag_err = 1'b0;
    logic [NUM_DEVICES*ADDR_BITS-1:0] tbl_addr = '0;
    logic [NUM_DEVICES*RATE_BITS-1:0] tbl_rate = '0;
    logic [NUM_DEVICES*TMO_BITS-1:0]  tbl_tmo = '0;

    res_t        expected_q [$];
    dir_row_t    dir_tab [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;
    bit          row_typed = 1'b0;
    res_t        row_result = '0;
    logic [31:0] tick = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic res_t sched_predict(cmd_t c);
        res_t        r;
        int unsigned d;
        int unsigned n;
        logic [31:0] elapsed;
        step_t       s;
        r = '0;
        d = active_dev;
        case (c.command)
            CMD_POLL:
            begin
                if (mgr_state == ST_IDLE)
                begin
                    if (pend != '0)
                        mgr_state = ST_ARB;
                end
                else if (mgr_state == ST_ARB)
                begin
                    mgr_state = ST_IDLE;
                    for (int i = NUM_DEVICES - 1; i >= 0; i--)
                        if (pend[i])
                        begin
                            active_dev = ACTIVE_W'(i);
                            mgr_state = ST_CONF;
                        end
                end
                else if (d >= NUM_DEVICES)
                begin
                    active_dev = ACTIVE_NONE;
                    mgr_state = ST_IDLE;
                end
                else
                begin
                    case (mgr_state)
                        ST_CONF:
                        begin
                            cur_step[d] = 0;
                            t_start = c.now_ms;
                            flag_done = 1'b0;
                            flag_err = 1'b0;
                            mgr_state = ST_EXEC;
                        end
                        ST_EXEC:
                        begin
                            s = slots[d * MAX_STEPS + (cur_step[d] % MAX_STEPS)];
                            flag_done = 1'b0;
                            flag_err = 1'b0;
                            r.kind = KIND_START;
                            r.out_device = 2'(d);
                            r.read_not_write = s.is_read;
                            r.target_addr = tbl_addr[d * ADDR_BITS +: ADDR_BITS];
                            r.rate_khz = tbl_rate[d * RATE_BITS +: RATE_BITS];
                            r.buffer_tag = s.tag;
                            r.length = s.length;
                            r.send_stop = s.stop;
                            mgr_state = ST_WAIT;
                        end
                        ST_WAIT:
                        begin
                            elapsed = c.now_ms - t_start;
                            if (flag_done)
                                mgr_state = ST_NEXT;
                            else if (flag_err)
                                mgr_state = ST_ERR;
                            else if (elapsed >= {16'd0, tbl_tmo[d * TMO_BITS +: TMO_BITS]})
                                mgr_state = ST_ERR;
                        end
                        ST_NEXT:
                        begin
                            n = cur_step[d] + 1;
                            cur_step[d] = n;
                            mgr_state = (n >= step_cnt[d]) ? ST_DONE : ST_EXEC;
                        end
                        default:
                        begin
                            r.kind = (mgr_state == ST_DONE) ? KIND_DONE : KIND_FAIL;
                            r.out_device = 2'(d);
                            pend[d] = 1'b0;
                            active_dev = ACTIVE_NONE;
                            mgr_state = ST_IDLE;
                        end
                    endcase
                end
            end
            CMD_LOAD:
            begin
                r.out_device = c.device;
                if (pend[c.device])
                    r.kind = KIND_REJECT;
                else
                begin
                    s.is_read = c.step_is_read;
                    s.length = c.step_length;
                    s.stop = c.step_stop;
                    s.tag = c.step_buffer_tag;
                    slots[{c.device, c.step_index}] = s;
                    slot_written[c.device][c.step_index] = 1'b1;
                    if (c.step_last)
                    begin
                        step_cnt[c.device] = c.step_index + 1;
                        pend[c.device] = 1'b1;
                    end
                    r.kind = KIND_ACCEPT;
                end
            end
            CMD_CANCEL:
                pend[c.device] = 1'b0;
            CMD_DONE:
                flag_done = 1'b1;
            CMD_ERROR:
                flag_err = 1'b1;
            default:
                ;
        endcase
        r.pending_mask = pend;
        r.manager_state = mgr_state;
        return r;
    endfunction

    function automatic cmd_t mk(logic [2:0] op, logic [1:0] dev, logic [2:0] idx, logic rd,
                                logic [15:0] len, logic stp, logic [7:0] tag, logic last,
                                logic [31:0] now);
        cmd_t c;
        c.command = op;
        c.device = dev;
        c.step_index = idx;
        c.step_is_read = rd;
        c.step_length = len;
        c.step_stop = stp;
        c.step_buffer_tag = tag;
        c.step_last = last;
        c.now_ms = now;
        return c;
    endfunction

    function automatic res_t quick(logic [2:0] kind, logic [1:0] dev, logic [3:0] mask,
                                   state_t st);
        res_t r;
        r = '0;
        r.kind = kind;
        r.out_device = dev;
        r.pending_mask = mask;
        r.manager_state = st;
        return r;
    endfunction

    function automatic void add_row(cmd_t c, bit typed, res_t r);
        dir_tab.push_back('{c, typed, r});
    endfunction

    // a step count may only cover slots that hold data
    function automatic logic last_ok(logic [1:0] d, logic [2:0] idx);
        logic [MAX_STEPS-1:0] need;
        need = (MAX_STEPS'(1) << idx) - MAX_STEPS'(1);
        return (slot_written[d] & need) == need;
    endfunction

    function automatic logic [31:0] advance_clock();
        tick = tick + $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 3)
            tick = tick + $urandom;
        return tick;
    endfunction

    function automatic cmd_t rand_load(logic [1:0] d, logic [2:0] idx, logic want_last);
        return mk(CMD_LOAD, d, idx, 1'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                  want_last & last_ok(d, idx), advance_clock());
    endfunction

    function automatic cmd_t rand_event(logic [2:0] op);
        return mk(op, 2'($urandom), 3'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
                  8'($urandom), 1'b0, advance_clock());
    endfunction

    task automatic send_cmd(cmd_t c, bit typed, res_t r);
        if (!steady)
            while ($urandom_range(0, 99) < 17)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c.command;
        cmd_ch.device <= c.device;
        cmd_ch.step_index <= c.step_index;
        cmd_ch.step_is_read <= c.step_is_read;
        cmd_ch.step_length <= c.step_length;
        cmd_ch.step_stop <= c.step_stop;
        cmd_ch.step_buffer_tag <= c.step_buffer_tag;
        cmd_ch.step_last <= c.step_last;
        cmd_ch.now_ms <= c.now_ms;
        row_typed <= typed;
        row_result <= r;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tables(logic [63:0] addr, logic [63:0] rate, logic [63:0] tmo);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ADDR;
        cfg_data <= addr;
        tbl_addr = addr[NUM_DEVICES*ADDR_BITS-1:0];
        @(negedge clk);
        cfg_index <= CFG_BAUD;
        cfg_data <= rate;
        tbl_rate = rate[NUM_DEVICES*RATE_BITS-1:0];
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= tmo;
        tbl_tmo = tmo;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned k;
        int unsigned m;
        int unsigned ev;
        logic [1:0]  d;
        cmd_t        c;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // whole request: steps in order, last one submits
                d = 2'($urandom);
                k = ($urandom_range(0, 9) == 0) ? MAX_STEPS - 1 : $urandom_range(0, 2);
                for (int j = 0; j <= k; j++)
                begin
                    send_cmd(rand_load(d, 3'(j), j == k), 1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 82)
            begin
                // polls with bus events in between
                m = $urandom_range(2, 10);
                repeat (m)
                begin
                    send_cmd(mk(CMD_POLL, 2'($urandom), 3'($urandom), 1'($urandom),
                                16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                                advance_clock()), 1'b0, '0);
                    sent++;
                    ev = $urandom_range(0, 99);
                    if (ev < 40)
                    begin
                        send_cmd(rand_event(CMD_DONE), 1'b0, '0);
                        sent++;
                    end
                    else if (ev < 47)
                    begin
                        send_cmd(rand_event(CMD_ERROR), 1'b0, '0);
                        sent++;
                    end
                end
            end
            else if (pick < 87)
            begin
                send_cmd(rand_event(CMD_CANCEL), 1'b0, '0);
                sent++;
            end
            else
            begin
                c = rand_load(2'($urandom), 3'($urandom), 1'($urandom));
                c.command = 3'($urandom);
                send_cmd(c, 1'b0, '0);
                if (c.command <= CMD_ERROR)
                    sent++;
            end
        end
    endtask

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // scoreboard: results are checked, then new transactions are predicted
    always @(posedge clk)
    begin : scoreboard
        res_t got;
        res_t want;
        res_t pred;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.kind, res_ch.out_device, res_ch.read_not_write,
                       res_ch.target_addr, res_ch.rate_khz, res_ch.buffer_tag,
                       res_ch.length, res_ch.send_stop, res_ch.pending_mask,
                       res_ch.manager_state};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction expected none actual %0h",
                             $time, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    cmp_field("kind", want.kind, got.kind);
                    cmp_field("out_device", want.out_device, got.out_device);
                    cmp_field("read_not_write", want.read_not_write, got.read_not_write);
                    cmp_field("target_addr", want.target_addr, got.target_addr);
                    cmp_field("rate_khz", want.rate_khz, got.rate_khz);
                    cmp_field("buffer_tag", want.buffer_tag, got.buffer_tag);
                    cmp_field("length", want.length, got.length);
                    cmp_field("send_stop", want.send_stop, got.send_stop);
                    cmp_field("pending_mask", want.pending_mask, got.pending_mask);
                    cmp_field("manager_state", want.manager_state, got.manager_state);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                pred = sched_predict({cmd_ch.command, cmd_ch.device, cmd_ch.step_index,
                                      cmd_ch.step_is_read, cmd_ch.step_length,
                                      cmd_ch.step_stop, cmd_ch.step_buffer_tag,
                                      cmd_ch.step_last, cmd_ch.now_ms});
                expected_q.push_back(row_typed ? row_result : pred);
            end
        end
    end

    initial
    begin : sink_side
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
        end
    end

    initial
    begin : stimulus
        logic [63:0] tmo;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_POLL;
        cmd_ch.device = '0;
        cmd_ch.step_index = '0;
        cmd_ch.step_is_read = 1'b0;
        cmd_ch.step_length = '0;
        cmd_ch.step_stop = 1'b0;
        cmd_ch.step_buffer_tag = '0;
        cmd_ch.step_last = 1'b0;
        cmd_ch.now_ms = '0;
        for (int i = 0; i < NUM_DEVICES; i++)
        begin
            step_cnt[i] = 0;
            cur_step[i] = 0;
            slot_written[i] = '0;
        end
        tick = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b1,
                quick(KIND_NONE, 2'd0, 4'h0, ST_IDLE));
        add_row(mk(CMD_UNUSED_LO, 2'd3, 3'd7, 1'b1, 16'hFFFF, 1'b1, 8'hFF, 1'b1,
                   32'hFFFF_FFFF), 1'b1, quick(KIND_NONE, 2'd0, 4'h0, ST_IDLE));
        add_row(mk(CMD_UNUSED_HI, 2'd2, 3'd1, 1'b0, 16'h8000, 1'b0, 8'h80, 1'b0,
                   32'h8000_0000), 1'b1, quick(KIND_NONE, 2'd0, 4'h0, ST_IDLE));
        add_row(mk(CMD_LOAD, 2'd0, 3'd0, 1'b1, 16'hFFFF, 1'b1, 8'hFF, 1'b0, 32'h0), 1'b1,
                quick(KIND_ACCEPT, 2'd0, 4'h0, ST_IDLE));
        add_row(mk(CMD_LOAD, 2'd0, 3'd1, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b1, 32'h0), 1'b1,
                quick(KIND_ACCEPT, 2'd0, 4'h1, ST_IDLE));
        // load while pending
        add_row(mk(CMD_LOAD, 2'd0, 3'd7, 1'b1, 16'h5555, 1'b1, 8'h33, 1'b1, 32'h0), 1'b1,
                quick(KIND_REJECT, 2'd0, 4'h1, ST_IDLE));
        add_row(mk(CMD_LOAD, 2'd1, 3'd0, 1'b0, 16'h1234, 1'b1, 8'h5A, 1'b1, 32'h0), 1'b1,
                quick(KIND_ACCEPT, 2'd1, 4'h3, ST_IDLE));
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFEE),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFEF),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFF0),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFF1),
                1'b0, '0);
        // done and error both seen: completion wins
        add_row(mk(CMD_DONE, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk(CMD_ERROR, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0005),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0006),
                1'b0, '0);
        // cancel of the running device
        add_row(mk(CMD_CANCEL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0007),
                1'b0, '0);
        // refused start
        add_row(mk(CMD_ERROR, 2'd3, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0008),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0009),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_000A),
                1'b0, '0);
        // arbitrate with nothing left pending
        add_row(mk(CMD_CANCEL, 2'd1, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_000B),
                1'b1, quick(KIND_NONE, 2'd0, 4'h0, ST_IDLE));
        // zero timeout fails at once, across the tick wrap
        add_row(mk(CMD_LOAD, 2'd1, 3'd0, 1'b1, 16'h00FF, 1'b0, 8'hC3, 1'b1, 32'h0), 1'b1,
                quick(KIND_ACCEPT, 2'd1, 4'h2, ST_IDLE));
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFFD),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFFE),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'hFFFF_FFFF),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0000),
                1'b0, '0);
        add_row(mk(CMD_POLL, 2'd0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0, 1'b0, 32'h0000_0001),
                1'b0, '0);

        write_tables({$urandom, 4'hF, 28'hFFF_FFFF}, {$urandom, 8'h00, 24'hFF_FFFF} |
                     64'h0000_00FF_FFFF_FFFF, 64'hFFFF_0001_0000_FFFF);
        foreach (dir_tab[i])
            send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
        drain();

        write_tables(64'h0, 64'h0, 64'h0);
        random_traffic(120);
        drain();

        steady = 1'b1;
        write_tables({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        random_traffic(160);
        drain();
        steady = 1'b0;

        tmo = '0;
        for (int i = 0; i < NUM_DEVICES; i++)
            tmo[i * TMO_BITS +: TMO_BITS] = 16'($urandom_range(0, 40));
        write_tables({$urandom, $urandom}, {$urandom, $urandom}, tmo);
        random_traffic(200);
        drain();

        write_tables('1, '1, '1);
        random_traffic(160);
        drain();

        write_tables({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        random_traffic(160);
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
